// ===== rtl/bsdp_pkg.sv =====
// Shared types, widths and constants for the block-scaled int16 dot product unit.
// Used by the lane, merge and scale modules, the top level and the checker.
package bsdp_pkg;

	// element and lane widths
	localparam int ELEM_W      = 16;
	localparam int LANES_MAX   = 4;
	localparam int LANES_DEF   = 4;
	localparam int LANE_PROD_W = 2 * ELEM_W;
	localparam int LANE_SUM_W  = LANE_PROD_W + 2;

	// fixed-point formats
	localparam int SCALE_W     = 32;
	localparam int SCALE_FRAC  = 24;
	localparam int ACC_FRAC    = 16;
	localparam int BLOCK_SUM_W = 36;
	localparam int ACC_W       = 64;
	localparam int SCORE_W     = 48;
	localparam int PROD_W      = 128;
	localparam int CHUNK_W     = 32;

	// right shifts applied after the wide products
	localparam int BLOCK_SHIFT = 2 * SCALE_FRAC - ACC_FRAC;
	localparam int SCORE_SHIFT = SCALE_FRAC;

	// attention scale after reset: 1.0 in Q8.24
	localparam logic signed [SCALE_W-1:0] ATTN_SCALE_RESET = 32'sd16777216;

	// stream payload layout
	localparam int TDATA_W = 8 * ELEM_W + 2 * SCALE_W;
	localparam int K_BASE  = LANES_MAX * ELEM_W;
	localparam int QS_BASE = 2 * LANES_MAX * ELEM_W;
	localparam int KS_BASE = QS_BASE + SCALE_W;

	// block close request from the merge stage to the scale unit
	typedef struct packed {
		logic                          valid;
		logic                          vector_end;
		logic signed [BLOCK_SUM_W-1:0] block_sum;
		logic signed [SCALE_W-1:0]     q_scale;
		logic signed [SCALE_W-1:0]     k_scale;
	} close_t;

	// status from the scale unit
	typedef struct packed {
		logic done;
		logic score_load;
	} scale_stat_t;

	// scale unit sequencer
	typedef enum logic [2:0] {
		SC_IDLE,
		SC_PREP,
		SC_MUL,
		SC_SIGN,
		SC_ROUND,
		SC_SAT,
		SC_ACC,
		SC_OUT
	} scale_state_t;

endpackage

// ===== rtl/bsdp_lane.sv =====
// One multiplier lane: registers the signed product of a query and key element.
// Depends on bsdp_pkg for the element and product widths.
module bsdp_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [bsdp_pkg::ELEM_W-1:0]   q,
	input  logic signed [bsdp_pkg::ELEM_W-1:0]   k,
	output logic signed [bsdp_pkg::LANE_PROD_W-1:0] prod_s1
);

	// capture the lane product on each accepted request
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= q * k;
		end
	end

endmodule

// ===== rtl/bsdp_merge.sv =====
// Merge stage: adds the lane products into the saturating block sum and raises
// a close request at block or vector end. Depends on bsdp_pkg.
module bsdp_merge #(
	parameter int LANES = bsdp_pkg::LANES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid_s1,
	input  logic                                    block_end_s1,
	input  logic                                    vector_end_s1,
	input  logic signed [bsdp_pkg::SCALE_W-1:0]     q_scale_s1,
	input  logic signed [bsdp_pkg::SCALE_W-1:0]     k_scale_s1,
	input  logic signed [bsdp_pkg::LANE_PROD_W-1:0] lane_prod_s1 [LANES],
	output bsdp_pkg::close_t                        close
);

	localparam int BSW = bsdp_pkg::BLOCK_SUM_W;
	localparam logic signed [BSW-1:0] BS_MAX = {1'b0, {(BSW-1){1'b1}}};
	localparam logic signed [BSW-1:0] BS_MIN = {1'b1, {(BSW-1){1'b0}}};

	logic signed [BSW-1:0]                   block_sum_q;
	logic signed [bsdp_pkg::LANE_SUM_W-1:0]  lane_sum;
	logic signed [BSW:0]                     wide_sum;
	logic signed [BSW-1:0]                   bs_next;
	logic                                    closing;

	// add up the active lanes
	always_comb begin
		lane_sum = '0;
		for (int l = 0; l < LANES; l++) begin
			lane_sum = lane_sum + bsdp_pkg::LANE_SUM_W'(lane_prod_s1[l]);
		end
	end

	// saturate the running block sum at the signed 36-bit range
	always_comb begin
		wide_sum = (BSW+1)'(block_sum_q) + (BSW+1)'(lane_sum);
		if (wide_sum[BSW] != wide_sum[BSW-1]) begin
			bs_next = wide_sum[BSW] ? BS_MIN : BS_MAX;
		end else begin
			bs_next = wide_sum[BSW-1:0];
		end
	end

	assign closing = valid_s1 && (block_end_s1 || vector_end_s1);

	// hand the closed block to the scale unit
	always_comb begin
		close.valid      = closing;
		close.vector_end = vector_end_s1;
		close.block_sum  = bs_next;
		close.q_scale    = q_scale_s1;
		close.k_scale    = k_scale_s1;
	end

	// advance the block sum, clear it when the block closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= '0;
		end else if (valid_s1) begin
			block_sum_q <= closing ? '0 : bs_next;
		end
	end

endmodule

// ===== rtl/bsdp_scale.sv =====
// Scale unit: applies the block scales, keeps the vector accumulator and forms
// the saturated score; its wide products share one 32x32 multiplier. Depends on bsdp_pkg.
module bsdp_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsdp_pkg::close_t                    close,
	input  logic signed [bsdp_pkg::SCALE_W-1:0] attn_scale,
	input  logic                                out_free,
	output bsdp_pkg::scale_stat_t               stat,
	output logic [bsdp_pkg::SCORE_W-1:0]        score
);

	localparam int PW  = bsdp_pkg::PROD_W;
	localparam int AW  = bsdp_pkg::ACC_W;
	localparam int SW  = bsdp_pkg::SCORE_W;
	localparam int CW  = bsdp_pkg::CHUNK_W;
	localparam logic [PW-1:0] HALF_BLK = (PW'(1) << bsdp_pkg::BLOCK_SHIFT) >> 1;
	localparam logic [PW-1:0] HALF_SC  = (PW'(1) << bsdp_pkg::SCORE_SHIFT) >> 1;
	localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic [SW-1:0] SC_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] SC_MIN = {1'b1, {(SW-1){1'b0}}};

	bsdp_pkg::scale_state_t state_q, state_d;

	logic signed [bsdp_pkg::BLOCK_SUM_W-1:0] bs_q;
	logic signed [AW-1:0]                    sp_q;
	logic signed [AW-1:0]                    acc_q;
	logic signed [AW-1:0]                    contrib_q;
	logic [AW-1:0]                           mag_a_q;
	logic [AW-1:0]                           mag_b_q;
	logic [PW-1:0]                           prod_q;
	logic [SW-1:0]                           score_q;
	logic [1:0]                              idx_q;
	logic                                    neg_q;
	logic                                    vend_q;
	logic                                    mode_q;

	logic signed [AW-1:0] op_a, op_b;
	logic [AW-1:0]        abs_a, abs_b;
	logic [CW-1:0]        chunk_a, chunk_b;
	logic [2*CW-1:0]      partial;
	logic [1:0]           pos;
	logic [PW-1:0]        partial_sh;
	logic [PW-1:0]        biased;
	logic [PW-1:0]        rounded;
	logic                 fits_acc, fits_score;
	logic signed [AW-1:0] sat_acc_w;
	logic [SW-1:0]        sat_score_w;
	logic signed [AW:0]   acc_sum;
	logic signed [AW-1:0] acc_next;

	// select operands: block sum by scale product, or accumulator by attention scale
	always_comb begin
		op_a  = mode_q ? acc_q : AW'(bs_q);
		op_b  = mode_q ? AW'(attn_scale) : sp_q;
		abs_a = op_a[AW-1] ? AW'(-op_a) : AW'(op_a);
		abs_b = op_b[AW-1] ? AW'(-op_b) : AW'(op_b);
	end

	// one 32x32 partial product per cycle, placed at its chunk offset
	always_comb begin
		chunk_a    = idx_q[1] ? mag_a_q[2*CW-1:CW] : mag_a_q[CW-1:0];
		chunk_b    = idx_q[0] ? mag_b_q[2*CW-1:CW] : mag_b_q[CW-1:0];
		partial    = chunk_a * chunk_b;
		pos        = {1'b0, idx_q[1]} + {1'b0, idx_q[0]};
		partial_sh = PW'(partial) << {pos, 5'd0};
	end

	// round to nearest, ties up, then arithmetic shift
	always_comb begin
		biased  = prod_q + (mode_q ? HALF_SC : HALF_BLK);
		rounded = mode_q ? PW'($signed(biased) >>> bsdp_pkg::SCORE_SHIFT)
		                 : PW'($signed(biased) >>> bsdp_pkg::BLOCK_SHIFT);
	end

	// saturate to 64 or 48 bits
	always_comb begin
		fits_acc    = (&prod_q[PW-1:AW-1]) || !(|prod_q[PW-1:AW-1]);
		fits_score  = (&prod_q[PW-1:SW-1]) || !(|prod_q[PW-1:SW-1]);
		sat_acc_w   = fits_acc ? prod_q[AW-1:0] : (prod_q[PW-1] ? ACC_MIN : ACC_MAX);
		sat_score_w = fits_score ? prod_q[SW-1:0] : (prod_q[PW-1] ? SC_MIN : SC_MAX);
	end

	// saturating accumulator add
	always_comb begin
		acc_sum = (AW+1)'(acc_q) + (AW+1)'(contrib_q);
		if (acc_sum[AW] != acc_sum[AW-1]) begin
			acc_next = acc_sum[AW] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_next = acc_sum[AW-1:0];
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsdp_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and status
	always_comb begin
		state_d         = state_q;
		stat.done       = 1'b0;
		stat.score_load = 1'b0;
		unique case (state_q)
			bsdp_pkg::SC_IDLE: begin
				if (close.valid) begin
					state_d = bsdp_pkg::SC_PREP;
				end
			end
			bsdp_pkg::SC_PREP: begin
				state_d = bsdp_pkg::SC_MUL;
			end
			bsdp_pkg::SC_MUL: begin
				if (idx_q == 2'd3) begin
					state_d = bsdp_pkg::SC_SIGN;
				end
			end
			bsdp_pkg::SC_SIGN: begin
				state_d = bsdp_pkg::SC_ROUND;
			end
			bsdp_pkg::SC_ROUND: begin
				state_d = bsdp_pkg::SC_SAT;
			end
			bsdp_pkg::SC_SAT: begin
				state_d = mode_q ? bsdp_pkg::SC_OUT : bsdp_pkg::SC_ACC;
			end
			bsdp_pkg::SC_ACC: begin
				if (vend_q) begin
					state_d = bsdp_pkg::SC_PREP;
				end else begin
					state_d   = bsdp_pkg::SC_IDLE;
					stat.done = 1'b1;
				end
			end
			bsdp_pkg::SC_OUT: begin
				if (out_free) begin
					state_d         = bsdp_pkg::SC_IDLE;
					stat.done       = 1'b1;
					stat.score_load = 1'b1;
				end
			end
		endcase
	end

	// mode and counter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			vend_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			unique case (state_q)
				bsdp_pkg::SC_IDLE: begin
					mode_q <= 1'b0;
					vend_q <= close.vector_end;
				end
				bsdp_pkg::SC_PREP: idx_q <= '0;
				bsdp_pkg::SC_MUL:  idx_q <= idx_q + 2'd1;
				bsdp_pkg::SC_ACC:  mode_q <= vend_q;
				bsdp_pkg::SC_SIGN, bsdp_pkg::SC_ROUND, bsdp_pkg::SC_SAT,
				bsdp_pkg::SC_OUT: begin
				end
			endcase
		end
	end

	// vector accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (state_q == bsdp_pkg::SC_ACC) begin
			acc_q <= acc_next;
		end else if (stat.score_load) begin
			acc_q <= '0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bsdp_pkg::SC_IDLE: begin
				bs_q <= close.block_sum;
				sp_q <= close.q_scale * close.k_scale;
			end
			bsdp_pkg::SC_PREP: begin
				mag_a_q <= abs_a;
				mag_b_q <= abs_b;
				neg_q   <= op_a[AW-1] ^ op_b[AW-1];
				prod_q  <= '0;
			end
			bsdp_pkg::SC_MUL:   prod_q <= prod_q + partial_sh;
			bsdp_pkg::SC_SIGN:  prod_q <= neg_q ? PW'(-prod_q) : prod_q;
			bsdp_pkg::SC_ROUND: prod_q <= rounded;
			bsdp_pkg::SC_SAT: begin
				contrib_q <= sat_acc_w;
				score_q   <= sat_score_w;
			end
			bsdp_pkg::SC_ACC, bsdp_pkg::SC_OUT: begin
			end
		endcase
	end

	assign score = score_q;

endmodule

// ===== rtl/block_scaled_int16_dot_product_unit.sv =====
// Block-scaled int16 dot product unit. Plain requests are taken one per cycle, back to back,
// while no closed block is pending. A request closing a block holds s_axis_tready low through
// capture, operand prep, four 32x32 partial products on the shared multiplier, sign, round,
// saturate and accumulate. A vector end runs the multiply twice, and s_axis_tready stays low
// until its score is loaded, including any wait for the output to drain.
// Reset (arst_n low) clears block sum, accumulator and output valid; attention scale 1.0.
module block_scaled_int16_dot_product_unit #(
	parameter int LANES = bsdp_pkg::LANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// q_lane0..3, k_lane0..3, q_block_scale, k_block_scale (lowest bits first)
	input  logic [bsdp_pkg::TDATA_W-1:0]        s_axis_tdata,
	// block_end
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tlast,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// score
	output logic [bsdp_pkg::SCORE_W-1:0]        m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_we,
	input  logic [bsdp_pkg::SCALE_W-1:0]        cfg_wdata
);

	localparam int EW = bsdp_pkg::ELEM_W;

	logic signed [bsdp_pkg::SCALE_W-1:0]     attn_scale_q;
	logic signed [bsdp_pkg::SCALE_W-1:0]     q_scale_s1, k_scale_s1;
	logic signed [bsdp_pkg::LANE_PROD_W-1:0] lane_prod_s1 [LANES];
	logic                                    valid_s1, block_end_s1, vector_end_s1;
	logic                                    end_pend_q;
	logic                                    in_take;
	logic                                    out_valid_q;
	logic                                    out_free;
	logic [bsdp_pkg::SCORE_W-1:0]            score;
	logic [bsdp_pkg::SCORE_W-1:0]            score_q;
	bsdp_pkg::close_t                        close;
	bsdp_pkg::scale_stat_t                   stat;

	// stall after a block-closing request until the scale unit finishes
	assign s_axis_tready = !end_pend_q;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// attention scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attn_scale_q <= bsdp_pkg::ATTN_SCALE_RESET;
		end else if (cfg_we) begin
			attn_scale_q <= cfg_wdata;
		end
	end

	// request control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			end_pend_q <= 1'b0;
		end else begin
			valid_s1 <= in_take;
			if (in_take && (s_axis_tuser || s_axis_tlast)) begin
				end_pend_q <= 1'b1;
			end else if (stat.done) begin
				end_pend_q <= 1'b0;
			end
		end
	end

	// request payload, first stage
	always_ff @(posedge clk) begin
		if (in_take) begin
			q_scale_s1    <= s_axis_tdata[bsdp_pkg::QS_BASE +: bsdp_pkg::SCALE_W];
			k_scale_s1    <= s_axis_tdata[bsdp_pkg::KS_BASE +: bsdp_pkg::SCALE_W];
			block_end_s1  <= s_axis_tuser;
			vector_end_s1 <= s_axis_tlast;
		end
	end

	// multiplier lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		bsdp_lane u_lane (
			.clk     (clk),
			.en      (in_take),
			.q       (s_axis_tdata[l*EW +: EW]),
			.k       (s_axis_tdata[bsdp_pkg::K_BASE + l*EW +: EW]),
			.prod_s1 (lane_prod_s1[l])
		);
	end

	bsdp_merge #(
		.LANES (LANES)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.block_end_s1  (block_end_s1),
		.vector_end_s1 (vector_end_s1),
		.q_scale_s1    (q_scale_s1),
		.k_scale_s1    (k_scale_s1),
		.lane_prod_s1  (lane_prod_s1),
		.close         (close)
	);

	bsdp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.close      (close),
		.attn_scale (attn_scale_q),
		.out_free   (out_free),
		.stat       (stat),
		.score      (score)
	);

	// output register: hold the score until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.score_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.score_load) begin
			score_q <= score;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = score_q;

endmodule

// ===== rtl/bsdp_checker.sv =====
// Port-level checks for the dot product unit, bound to the top level.
// Depends on bsdp_pkg and block_scaled_int16_dot_product_unit.
module bsdp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tuser,
	input logic                         s_axis_tlast,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [bsdp_pkg::SCORE_W-1:0] m_axis_tdata,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready
);

	// a stalled score holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("score dropped or changed while stalled");

	// a block- or vector-closing request stalls the input
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast)
		|=> !s_axis_tready)
		else $error("input not stalled after closing request");

	// plain requests never stall the input
	a_plain_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast
		|=> s_axis_tready)
		else $error("input stalled after plain request");

	// a new score only appears while a vector end is in progress
	a_score_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("score without pending vector end");

endmodule

bind block_scaled_int16_dot_product_unit bsdp_checker u_bsdp_checker (.*);
